// ===== hw/rtl/sipq_pkg.sv =====
package sipq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int ID_W            = 8;
	localparam int KEY_W           = 8;
	localparam int OCC_W           = 6;
	localparam int STATUS_W        = 2;
	localparam int ENTRY_W         = ID_W + KEY_W;
	localparam int S_TDATA_W       = 16;
	localparam int M_TDATA_W       = 24;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ_STEP,
		S_ENQ_CMP,
		S_DEQ_RD,
		S_DEQ_WAIT,
		S_RESP
	} sipq_state_t;

endpackage

// ===== hw/rtl/sorted_insert_priority_queue.sv =====
// Channel | Direction | Handshake        | tuser           | tdata (lowest bit up)
// s       | in        | s_tvalid/s_tready| [0] mode        | [7:0] sender_id, [15:8] friend_count
// m       | out       | m_tvalid/m_tready| [1:0] status   | [7:0] out_sender_id,
//         |           |                  |                 | [15:8] out_friend_count, [21:16] occupancy
//
// One request at a time. Full enqueue and empty dequeue go straight to the response, and
// dequeue reads the head entry and then pops it. Enqueue shifts each held entry with a
// smaller key up one slot, then writes the new entry; each shifted entry costs one read and one
// compare-and-write on the single-port entry memory through the shared ring address adder.
// arst_n clears the queue to empty; the entry memory itself is not cleared.
// A stalled result holds in the output register; the next request is taken meanwhile.
module sorted_insert_priority_queue
	import sipq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] sender_id, [15:8] friend_count
	input  logic                 s_tuser,  // [0] mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [7:0] out_sender_id, [15:8] out_friend_count,
	                                       // [21:16] occupancy, [23:22] zero
	output logic [STATUS_W-1:0]  m_tuser   // [1:0] status
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	sipq_state_t state_q, state_nxt;

	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   pos_q;
	logic [ID_W-1:0]    id_q;
	logic [KEY_W-1:0]   key_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [KEY_W-1:0]   res_key_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [OCC_W-1:0]   out_occ_q;
	logic               out_valid_q;

	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	logic               s_fire;
	logic               in_mode;
	logic               is_full;
	logic               is_empty;
	logic               out_free;
	logic               stop_here;
	logic [IDX_W-1:0]   k_sel;
	logic [IDX_W:0]     ring_sum;
	logic [IDX_W-1:0]   addr;
	logic               mem_we;
	logic               mem_re;
	logic               wr_new;
	logic [ENTRY_W-1:0] wr_data;
	logic [CNT_W-1:0]   count_dec;

	assign in_mode   = s_tuser;
	assign s_fire    = s_tvalid && s_tready;
	assign is_full   = (count_q == DEPTH_CNT);
	assign is_empty  = (count_q == '0);
	assign out_free  = !out_valid_q || m_tready;
	assign stop_here = (rd_data_q[KEY_W-1:0] >= key_q);
	assign count_dec = count_q - CNT_W'(1);

	// shared ring address unit: head plus offset, wrapped once
	always_comb begin
		k_sel = pos_q[IDX_W-1:0];
		if (state_q == S_ENQ_STEP && pos_q != '0) begin
			k_sel = IDX_W'(pos_q - CNT_W'(1));
		end else if (state_q == S_DEQ_RD) begin
			k_sel = '0;
		end
		ring_sum = {1'b0, head_q} + {1'b0, k_sel};
		if (ring_sum >= DEPTH_EXT) begin
			addr = IDX_W'(ring_sum - DEPTH_EXT);
		end else begin
			addr = ring_sum[IDX_W-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					if (in_mode == MODE_ENQ) begin
						state_nxt = is_full ? S_RESP : S_ENQ_STEP;
					end else begin
						state_nxt = is_empty ? S_RESP : S_DEQ_RD;
					end
				end
			end
			S_ENQ_STEP: state_nxt = (pos_q == '0) ? S_RESP : S_ENQ_CMP;
			S_ENQ_CMP:  state_nxt = stop_here ? S_RESP : S_ENQ_STEP;
			S_DEQ_RD:   state_nxt = S_DEQ_WAIT;
			S_DEQ_WAIT: state_nxt = S_RESP;
			S_RESP:     state_nxt = out_free ? S_IDLE : S_RESP;
			default:    state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		wr_new   = 1'b0;
		case (state_q)
			S_IDLE:     s_tready = 1'b1;
			S_ENQ_STEP: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
					wr_new = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_ENQ_CMP: begin
				mem_we = 1'b1;
				wr_new = stop_here;
			end
			S_DEQ_RD:   mem_re = 1'b1;
			default: begin
			end
		endcase
	end

	assign wr_data = wr_new ? {id_q, key_q} : rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr_new) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == S_DEQ_WAIT) begin
				count_q <= count_dec;
				if (count_dec == '0) begin
					head_q <= '0;
				end else if (head_q == IDX_W'(QUEUE_DEPTH - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + IDX_W'(1);
				end
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			id_q      <= s_tdata[ID_W-1:0];
			key_q     <= s_tdata[ID_W +: KEY_W];
			pos_q     <= count_q;
			res_id_q  <= '0;
			res_key_q <= '0;
			if (in_mode == MODE_ENQ && is_full) begin
				res_status_q <= ST_FULL;
			end else if (in_mode == MODE_DEQ && is_empty) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (state_q == S_ENQ_CMP && !stop_here) begin
			pos_q <= pos_q - CNT_W'(1);
		end
		if (state_q == S_DEQ_WAIT) begin
			res_id_q  <= rd_data_q[KEY_W +: ID_W];
			res_key_q <= rd_data_q[KEY_W-1:0];
		end
		if (state_q == S_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_key_q    <= res_key_q;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {(M_TDATA_W - OCC_W - KEY_W - ID_W)'(0), out_occ_q, out_key_q, out_id_q};

endmodule

// ===== hw/rtl/sipq_checker.sv =====
module sipq_checker
	import sipq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]  m_tuser
);

	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// drop ready after taking a request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tdata[21:16] == FULL_OCC && m_tdata[15:0] == '0)
		else $error("full status with wrong occupancy or data");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == '0)
		else $error("empty status with nonzero fields");

endmodule

bind sorted_insert_priority_queue sipq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_sipq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/sipq_tb_pkg.sv =====
package sipq_tb_pkg;
	import sipq_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} queue_entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [KEY_W-1:0]    key;
		logic [OCC_W-1:0]    occ;
	} queue_result_t;

	class queue_scoreboard;
		int            depth;
		int            errors;
		queue_entry_t  held[$];
		queue_result_t awaited[$];

		function new(int queue_depth);
			depth  = queue_depth;
			errors = 0;
		endfunction

		function int held_count();
			return held.size();
		endfunction

		function int awaited_count();
			return awaited.size();
		endfunction

		function void note_request(logic mode, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
			queue_result_t want;
			queue_entry_t  e;
			int            pos;
			want = '0;
			want.status = ST_OK;
			if (mode == MODE_ENQ) begin
				if (held.size() >= depth) begin
					want.status = ST_FULL;
				end else begin
					e.id  = id;
					e.key = key;
					pos = held.size();
					while (pos > 0 && held[pos-1].key < key)
						pos--;
					held.insert(pos, e);
				end
			end else begin
				if (held.size() == 0) begin
					want.status = ST_EMPTY;
				end else begin
					e = held.pop_front();
					want.id  = e.id;
					want.key = e.key;
				end
			end
			want.occ = OCC_W'(held.size());
			awaited.push_back(want);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
				logic [KEY_W-1:0] key, logic [OCC_W-1:0] occ);
			queue_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: expected none, got status %0d id %0d key %0d occupancy %0d",
					$time, status, id, key, occ);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("status", 8'(want.status), 8'(status));
			compare_field("out_sender_id", want.id, id);
			compare_field("out_friend_count", want.key, key);
			compare_field("occupancy", 8'(want.occ), 8'(occ));
		endfunction
	endclass

endpackage

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sipq_pkg::*;
	import sipq_tb_pkg::*;

	localparam int DEPTH        = QUEUE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 100;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	queue_scoreboard sb = new(DEPTH);
	bit              steady;
	int              hold_left;
	int              requests_sent;
	int              cycles;

	sorted_insert_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				sb.check_result(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[21:16]);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 21);
			end
		end
	end

	function automatic logic [KEY_W-1:0] pick_key(bit narrow);
		if (narrow)
			return KEY_W'($urandom_range(3) * 85);
		return KEY_W'($urandom_range(255));
	endfunction

	task automatic send_request(logic mode, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
		while (!steady && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {key, id};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		sb.note_request(mode, id, key);
		requests_sent++;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited_count() != 0);
	endtask

	task automatic fill_queue(bit narrow);
		int extra;
		extra = $urandom_range(1, 3);
		while (sb.held_count() < DEPTH)
			send_request(MODE_ENQ, ID_W'($urandom_range(255)), pick_key(narrow));
		repeat (extra)
			send_request(MODE_ENQ, ID_W'($urandom_range(255)), pick_key(narrow));
	endtask

	task automatic drain_queue();
		int extra;
		extra = $urandom_range(1, 2);
		while (sb.held_count() > 0)
			send_request(MODE_DEQ, ID_W'($urandom_range(255)), KEY_W'($urandom_range(255)));
		repeat (extra)
			send_request(MODE_DEQ, ID_W'($urandom_range(255)), KEY_W'($urandom_range(255)));
	endtask

	task automatic mixed_run(bit narrow);
		int count;
		count = $urandom_range(20, 40);
		repeat (count)
			send_request($urandom_range(1) ? MODE_DEQ : MODE_ENQ,
				ID_W'($urandom_range(255)), pick_key(narrow));
	endtask

	initial begin
		int  pick;
		bit  narrow;
		bit  hold_done;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = MODE_ENQ;
		steady        = 1'b0;
		hold_left     = 0;
		requests_sent = 0;
		hold_done     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_DEQ, 8'h00, 8'h00);
		send_request(MODE_ENQ, 8'h00, 8'h00);
		send_request(MODE_ENQ, 8'hFF, 8'hFF);
		send_request(MODE_ENQ, 8'h5A, 8'h80);
		send_request(MODE_ENQ, 8'hA5, 8'h80);
		send_request(MODE_ENQ, 8'h01, 8'h00);
		send_request(MODE_ENQ, 8'h7F, 8'hFE);
		repeat (6)
			send_request(MODE_DEQ, 8'hFF, 8'hFF);
		send_request(MODE_DEQ, 8'hFF, 8'hFF);
		send_request(MODE_ENQ, 8'h33, 8'h40);
		send_request(MODE_DEQ, 8'h00, 8'h00);
		send_request(MODE_DEQ, 8'h00, 8'h00);
		wait_drain();

		requests_sent = 0;
		while (requests_sent < RANDOM_ITEMS) begin
			steady = (requests_sent > 400 && requests_sent < 650);
			narrow = $urandom_range(1);
			pick   = $urandom_range(9);
			if (!hold_done && requests_sent > 800) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				pick      = 0;
			end
			if (pick <= 3)
				fill_queue(narrow);
			else if (pick <= 6)
				drain_queue();
			else
				mixed_run(narrow);
			if ($urandom_range(7) == 0)
				wait_drain();
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited_count() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
